[rtl/bfq_pkg.sv]
// Shared types, codes and constants of the bounded FIFO queue.
package bfq_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam int DATA_W          = 32;
	localparam int CAP_W           = 7;
	localparam int SPACE_W         = 7;

	localparam logic [1:0] REQ_ENQUEUE = 2'd0;
	localparam logic [1:0] REQ_DEQUEUE = 2'd1;
	localparam logic [1:0] REQ_PEEK    = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [DATA_W-1:0] data_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [DATA_W-1:0]  data_out;
		logic               is_empty;
		logic [SPACE_W-1:0] free_space;
		logic               is_unlimited;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_ready;
	} dp_status_t;

endpackage

[rtl/bfq_ctrl.sv]
// Controller state machine that sequences one request at a time.
module bfq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bfq_pkg::dp_status_t sts,
	output bfq_pkg::ctrl_cmd_t  cmd
);

	bfq_pkg::ctrl_state_t state_q;
	bfq_pkg::ctrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			bfq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = bfq_pkg::ST_EXEC;
				end
			end
			bfq_pkg::ST_EXEC: begin
				if (sts.out_ready) begin
					state_next = bfq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bfq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			bfq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			bfq_pkg::ST_EXEC: begin
				cmd.commit = sts.out_ready;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

[rtl/bfq_datapath.sv]
// Datapath: word memory, pointers, fill count, limit register and result register.
module bfq_datapath #(
	parameter int STORE_DEPTH = bfq_pkg::STORE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfq_pkg::in_item_t             in_item,
	input  logic                          cfg_we,
	input  logic [bfq_pkg::CAP_W-1:0]     cfg_data,
	input  bfq_pkg::ctrl_cmd_t            cmd,
	output bfq_pkg::dp_status_t           sts,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bfq_pkg::out_item_t            out_item
);

	localparam int PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int LIM_W = (CNT_W > bfq_pkg::CAP_W) ? CNT_W : bfq_pkg::CAP_W;

	logic [bfq_pkg::DATA_W-1:0] mem [STORE_DEPTH];

	logic [bfq_pkg::CAP_W-1:0]  cap_q;
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [PTR_W-1:0]           wr_ptr_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [1:0]                 req_q;
	logic [bfq_pkg::DATA_W-1:0] data_q;
	logic [bfq_pkg::DATA_W-1:0] rd_data_q;
	logic                       out_valid_q;
	bfq_pkg::out_item_t         out_q;

	logic [LIM_W-1:0]           limit;
	logic [LIM_W-1:0]           cnt_ext;
	logic                       do_enq;
	logic                       do_deq;
	logic [CNT_W-1:0]           cnt_next;
	logic [LIM_W-1:0]           space;
	bfq_pkg::out_item_t         result;

	always_comb begin
		if (cap_q == '0 || LIM_W'(cap_q) > LIM_W'(STORE_DEPTH)) begin
			limit = LIM_W'(STORE_DEPTH);
		end else begin
			limit = LIM_W'(cap_q);
		end
	end

	assign cnt_ext = LIM_W'(cnt_q);

	always_comb begin
		do_enq          = 1'b0;
		do_deq          = 1'b0;
		result.status   = bfq_pkg::ST_OK;
		result.data_out = '0;
		case (req_q)
			bfq_pkg::REQ_ENQUEUE: begin
				if (cnt_ext >= limit) begin
					result.status = bfq_pkg::ST_FULL;
				end else begin
					do_enq = 1'b1;
				end
			end
			bfq_pkg::REQ_DEQUEUE, bfq_pkg::REQ_PEEK: begin
				if (cnt_q == '0) begin
					result.status = bfq_pkg::ST_EMPTY;
				end else begin
					result.data_out = rd_data_q;
					do_deq          = (req_q == bfq_pkg::REQ_DEQUEUE);
				end
			end
			default: begin
				result.status = bfq_pkg::ST_OK;
			end
		endcase

		if (do_enq) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (do_deq) begin
			cnt_next = cnt_q - CNT_W'(1);
		end else begin
			cnt_next = cnt_q;
		end

		space = (limit > LIM_W'(cnt_next)) ? (limit - LIM_W'(cnt_next)) : '0;

		result.is_empty     = (cnt_next == '0);
		result.free_space   = space[bfq_pkg::SPACE_W-1:0];
		result.is_unlimited = (cap_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.commit) begin
				cnt_q <= cnt_next;
				if (do_enq) begin
					wr_ptr_q <= (wr_ptr_q == PTR_W'(STORE_DEPTH - 1)) ? '0
					            : wr_ptr_q + PTR_W'(1);
				end
				if (do_deq) begin
					rd_ptr_q <= (rd_ptr_q == PTR_W'(STORE_DEPTH - 1)) ? '0
					            : rd_ptr_q + PTR_W'(1);
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The head word is read every cycle; it is settled by the time a request executes.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_ptr_q];
		if (cmd.commit && do_enq) begin
			mem[wr_ptr_q] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= in_item.req_type;
			data_q <= in_item.data_in;
		end
		if (cmd.commit) begin
			out_q <= result;
		end
	end

	assign sts.out_ready = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign out_item      = out_q;

endmodule

[rtl/bounded_fifo_queue_core.sv]
// Top level of the bounded FIFO queue with a programmable capacity limit.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid / in_stall  in_item  (req_type, data_in)
//   out       output     out_valid/out_stall  out_item (status, data_out, flags, space)
//   cfg       input      cfg_we               cfg_data (capacity_limit)
//
// Each request takes two steps: one to take the transaction in and one to execute it
// against the registered read of the word memory's head entry.
// A new request is taken while the previous result still waits in the output register.
// A stall on the output holds execution until the result register frees up.
// Reset clears the pointers, the fill count, the limit and the handshake state;
// the word memory is not cleared and needs no clearing pass.
module bounded_fifo_queue_core #(
	parameter int STORE_DEPTH = bfq_pkg::STORE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  bfq_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output bfq_pkg::out_item_t        out_item,
	input  logic                      cfg_we,
	input  logic [bfq_pkg::CAP_W-1:0] cfg_data
);

	bfq_pkg::ctrl_cmd_t  cmd;
	bfq_pkg::dp_status_t sts;

	bfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfq_datapath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
